@@ rtl/pooled_linked_list_engine_macros.svh @@
// Assertion macros for the linked-list engine.
`ifndef POOLED_LINKED_LIST_ENGINE_MACROS_SVH
`define POOLED_LINKED_LIST_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define PLL_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define PLL_ASSERT_NXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define PLL_ASSERT_IMP(label, clk, rst, a, c, msg)
`define PLL_ASSERT_NXT(label, clk, rst, a, c, msg)
`endif
`endif

@@ rtl/pll_pkg.sv @@
package pll_pkg;
  localparam int DEFAULT_CAPACITY = 64;
  localparam int KEY_W = 64;
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0, OP_INSERT_AFTER = 2'd1, OP_REMOVE = 2'd2, OP_FIND = 2'd3
  } op_t;
  typedef enum logic [1:0] {
    ST_DONE = 2'd0, ST_DUPLICATE = 2'd1, ST_FULL = 2'd2, ST_NOT_FOUND = 2'd3
  } status_t;
endpackage

@@ rtl/pll_if.sv @@
interface pll_in_if import pll_pkg::*; (input logic clk);
  logic valid;
  logic ready;
  logic [1:0] operation;
  logic [KEY_W-1:0] key;
  logic [KEY_W-1:0] new_value;
  modport source (output valid, operation, key, new_value, input ready);
  modport sink (input valid, operation, key, new_value, output ready);
endinterface

interface pll_out_if (input logic clk);
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [5:0] slot_index;
  logic [6:0] entry_count;
  modport source (output valid, status, slot_index, entry_count, input ready);
  modport sink (input valid, status, slot_index, entry_count, output ready);
endinterface

@@ rtl/pooled_linked_list_engine.sv @@
// Pooled linked-list engine. Values and links live in two synchronous RAMs; each list slot
// is visited by a read followed by a compare. Insert, remove and find walk up to CAPACITY
// slots and insert-after walks twice. After reset the link RAM is initialized by a pass
// over all CAPACITY slots during which no transfer is accepted. Results are held in an
// output register until taken; the next item is accepted once that register is free.
`include "pooled_linked_list_engine_macros.svh"
module pooled_linked_list_engine import pll_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input logic clk,
  input logic rst,
  pll_in_if.sink in_ch,
  pll_out_if.source out_ch
);
  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam logic [LW-1:0] NIL = LW'(CAPACITY);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_WALK_RD, S_WALK_CHK, S_WALK2, S_DECIDE, S_FREE_RD, S_COMMIT,
    S_LINK_RD, S_LINK_WR, S_OUT
  } state_t;

  logic [KEY_W-1:0] val_mem [CAPACITY];
  logic [LW-1:0] link_mem [CAPACITY];
  logic [KEY_W-1:0] val_rd;
  logic [LW-1:0] link_rd;

  state_t state;
  op_t op;
  logic [KEY_W-1:0] nv, target;
  logic [LW-1:0] cur, trail, hit, anchor, prev_hit, list_head, free_head, fnext;
  logic [LW-1:0] steps;
  logic [LW-1:0] count;
  logic pass2;
  logic [AW-1:0] init_idx;
  logic [1:0] st;
  logic [5:0] slot_o;

  logic ram_we_v, ram_we_l;
  logic [AW-1:0] wa_v, wa_l, ra;
  logic [LW-1:0] wd_l;

  always_ff @(posedge clk) begin
    if (ram_we_v) val_mem[wa_v] <= nv;
    if (ram_we_l) link_mem[wa_l] <= wd_l;
    val_rd <= val_mem[ra];
    link_rd <= link_mem[ra];
  end

  logic full;
  assign full = (count >= LW'(CAPACITY)) || (free_head >= NIL);
  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.status = st;
  assign out_ch.slot_index = slot_o;
  assign out_ch.entry_count = 7'(count);

  always_comb begin
    ram_we_v = 1'b0;
    ram_we_l = 1'b0;
    wa_v = cur[AW-1:0];
    wa_l = cur[AW-1:0];
    wd_l = cur;
    ra = cur[AW-1:0];
    unique case (state)
      S_INIT: begin
        ram_we_l = 1'b1;
        wa_l = init_idx;
        wd_l = (init_idx == AW'(CAPACITY - 1)) ? NIL : LW'(init_idx) + LW'(1);
      end
      S_FREE_RD: ra = free_head[AW-1:0];
      S_COMMIT: begin
        ram_we_v = 1'b1;
        wa_v = free_head[AW-1:0];
        ra = anchor[AW-1:0];
        if (op == OP_INSERT) begin
          ram_we_l = 1'b1;
          wa_l = free_head[AW-1:0];
          wd_l = list_head;
        end else if (op == OP_REMOVE) begin
          ra = hit[AW-1:0];
        end
      end
      S_LINK_WR: begin
        ram_we_l = 1'b1;
        if (op == OP_INSERT_AFTER) begin
          wa_l = anchor[AW-1:0];
          wd_l = fnext;
        end else begin
          wa_l = hit[AW-1:0];
          wd_l = free_head;
        end
      end
      S_LINK_RD: begin
        if (op == OP_INSERT_AFTER) begin
          ram_we_l = 1'b1;
          wa_l = fnext[AW-1:0];
          wd_l = link_rd;
        end else if (prev_hit != NIL) begin
          ram_we_l = 1'b1;
          wa_l = prev_hit[AW-1:0];
          wd_l = link_rd;
        end
      end
      default: ;
    endcase
    ram_we_v = ram_we_v && (op == OP_INSERT || op == OP_INSERT_AFTER);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      init_idx <= '0;
      list_head <= NIL;
      free_head <= '0;
      count <= '0;
    end else begin
      unique case (state)
        S_INIT: begin
          init_idx <= init_idx + AW'(1);
          if (init_idx == AW'(CAPACITY - 1)) state <= S_IDLE;
        end
        S_IDLE: if (in_ch.valid) begin
          op <= op_t'(in_ch.operation);
          nv <= in_ch.new_value;
          target <= (in_ch.operation == OP_INSERT) ? in_ch.new_value : in_ch.key;
          cur <= list_head;
          trail <= NIL;
          steps <= '0;
          pass2 <= 1'b0;
          hit <= NIL;
          state <= S_WALK_RD;
        end
        S_WALK_RD: begin
          if (steps >= LW'(CAPACITY) || cur >= NIL) begin
            hit <= NIL;
            state <= S_DECIDE;
          end else state <= S_WALK_CHK;
        end
        S_WALK_CHK: begin
          if (val_rd == target) begin
            hit <= cur;
            prev_hit <= trail;
            state <= S_DECIDE;
          end else begin
            trail <= cur;
            cur <= link_rd;
            steps <= steps + LW'(1);
            state <= S_WALK_RD;
          end
        end
        S_DECIDE: begin
          slot_o <= '0;
          st <= ST_DONE;
          state <= S_OUT;
          unique case (op)
            OP_INSERT:
              if (hit != NIL) st <= ST_DUPLICATE;
              else if (full) st <= ST_FULL;
              else state <= S_FREE_RD;
            OP_INSERT_AFTER:
              if (!pass2) begin
                if (hit == NIL) st <= ST_NOT_FOUND;
                else begin
                  anchor <= hit;
                  pass2 <= 1'b1;
                  target <= nv;
                  cur <= list_head;
                  steps <= '0;
                  hit <= NIL;
                  state <= S_WALK_RD;
                end
              end else if (hit != NIL) st <= ST_DUPLICATE;
              else if (full) st <= ST_FULL;
              else state <= S_FREE_RD;
            OP_REMOVE:
              if (hit == NIL) st <= ST_NOT_FOUND;
              else state <= S_COMMIT;
            default:
              if (hit == NIL) st <= ST_NOT_FOUND;
              else slot_o <= 6'(hit);
          endcase
        end
        S_FREE_RD: state <= S_COMMIT;
        S_COMMIT: begin
          if (op == OP_INSERT) begin
            list_head <= free_head;
            free_head <= link_rd;
            count <= count + LW'(1);
            state <= S_OUT;
          end else if (op == OP_INSERT_AFTER) begin
            fnext <= free_head;
            free_head <= link_rd;
            count <= count + LW'(1);
            state <= S_LINK_RD;
          end else begin
            state <= S_LINK_RD;
          end
        end
        S_LINK_RD: begin
          if (op == OP_REMOVE) begin
            if (prev_hit == NIL) list_head <= link_rd;
            if (count != '0) count <= count - LW'(1);
          end
          state <= S_LINK_WR;
        end
        S_LINK_WR: begin
          if (op == OP_REMOVE) free_head <= hit;
          state <= S_OUT;
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `PLL_ASSERT_IMP(a_no_dual_hs, clk, rst, in_ch.ready, !out_ch.valid, "ready with result")
  `PLL_ASSERT_NXT(a_out_holds, clk, rst, out_ch.valid && !out_ch.ready, $stable(st) && out_ch.valid, "result moved")
  `PLL_ASSERT_IMP(a_count_range, clk, rst, 1'b1, count <= LW'(CAPACITY), "count too large")
  `PLL_ASSERT_NXT(a_accept_busy, clk, rst, in_ch.valid && in_ch.ready, !in_ch.ready, "accepted twice")
endmodule
